// ===== src/odq_pkg.sv =====
package odq_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned PROD_W   = 16;
  localparam int unsigned SCALED_W = 24;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned FRAC_W   = 9;
  localparam int unsigned X_W      = 16;
  localparam int unsigned RCP_W    = X_W + 1;
  localparam int unsigned RCP255_W = 17;

  localparam int unsigned MAX_CODE = 255;

  // floor(2^24 / 255), quotient estimate for the step split
  localparam logic [RCP255_W-1:0] RCP_255 = RCP255_W'((1 << SCALED_W) / MAX_CODE);

  // Bayer 4x4 thresholds pre-scaled by 255/16, index {row[1:0], column[1:0]}
  localparam logic [DATA_W-1:0] THRESH_TAB [16] = '{
    8'd0,   8'd127, 8'd31,  8'd159,
    8'd191, 8'd63,  8'd223, 8'd95,
    8'd47,  8'd175, 8'd15,  8'd143,
    8'd239, 8'd111, 8'd207, 8'd79
  };

  typedef struct packed {
    logic              full;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] div;
    logic [RCP_W-1:0]  rcp;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [DATA_W-1:0]   inten;
    logic [DATA_W-1:0]   thresh;
    logic [SCALED_W-1:0] scaled;
  } scaled_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] step;
  } step_t;

endpackage

// ===== src/odq_cfg.sv =====
module odq_cfg #(
  parameter int unsigned INTERNAL_LEVELS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [odq_pkg::DATA_W-1:0]  cfg_wdata_i,
  output odq_pkg::cfg_t               cfg_o
);
  import odq_pkg::*;

  localparam logic [DATA_W-1:0] DIV     = DATA_W'(INTERNAL_LEVELS - 1);
  localparam logic [RCP_W-1:0]  RCP_DIV = RCP_W'((1 << X_W) / (INTERNAL_LEVELS - 1));
  localparam logic              RST_FULL = (INTERNAL_LEVELS <= 2);
  localparam cfg_t CFG_RST = '{
    full: RST_FULL,
    top:  DATA_W'(1),
    div:  RST_FULL ? DIV : DATA_W'(1),
    rcp:  RST_FULL ? RCP_DIV : RCP_W'(1 << X_W)
  };

  logic [RCP_W-1:0]  rcp_tab [256];
  logic [DATA_W-1:0] lv;
  cfg_t              cfg_d;
  cfg_t              cfg_q;

  for (genvar g = 0; g < 256; g++) begin : g_rcp
    localparam int unsigned DEN = (g == 0) ? 1 : g;
    assign rcp_tab[g] = RCP_W'((1 << X_W) / DEN);
  end

  always_comb begin
    lv         = (cfg_wdata_i < DATA_W'(2)) ? DATA_W'(2) : cfg_wdata_i;
    cfg_d.top  = lv - DATA_W'(1);
    cfg_d.full = ({1'b0, lv} >= (DATA_W + 1)'(INTERNAL_LEVELS));
    cfg_d.div  = cfg_d.full ? DIV : cfg_d.top;
    cfg_d.rcp  = cfg_d.full ? RCP_DIV : rcp_tab[cfg_d.top];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/odq_scale.sv =====
module odq_scale #(
  parameter int unsigned INTERNAL_LEVELS = 16,
  parameter int unsigned MAX_INTENSITY   = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [odq_pkg::DATA_W-1:0]  intensity_i,
  input  logic [1:0]                  column_i,
  input  logic [1:0]                  row_i,
  input  odq_pkg::cfg_t               cfg_i,
  output odq_pkg::scaled_t            sc_o
);
  import odq_pkg::*;

  localparam logic [DATA_W-1:0]   MAX_INT = DATA_W'(MAX_INTENSITY);
  localparam logic [DATA_W-1:0]   DIV     = DATA_W'(INTERNAL_LEVELS - 1);
  localparam logic [SCALED_W:0]   RCP     =
    (SCALED_W + 1)'((1 << SCALED_W) / (INTERNAL_LEVELS - 1));

  logic [DATA_W-1:0]          inten_c;
  logic [PROD_W-1:0]          prod_c;
  logic [SCALED_W-1:0]        num_c;
  logic [2*SCALED_W:0]        mul_c;
  logic [SCALED_W+DATA_W-1:0] back_c;
  logic [SCALED_W-1:0]        rem_c;
  logic [SCALED_W-1:0]        quo_c;

  logic                v1_q, v2_q, v3_q;
  logic [DATA_W-1:0]   inten1_q, inten2_q, inten3_q;
  logic [DATA_W-1:0]   thresh1_q, thresh2_q, thresh3_q;
  logic [PROD_W-1:0]   prod1_q;
  logic [SCALED_W-1:0] num2_q, quo2_q, scaled3_q;

  assign inten_c = (intensity_i > MAX_INT) ? MAX_INT : intensity_i;
  assign prod_c  = inten_c * cfg_i.top;
  assign num_c   = {prod1_q, 8'h00} - {8'h00, prod1_q};
  assign mul_c   = num_c * RCP;
  assign back_c  = quo2_q * DIV;
  assign rem_c   = num2_q - back_c[SCALED_W-1:0];
  assign quo_c   = quo2_q + SCALED_W'(rem_c >= SCALED_W'(DIV));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten1_q  <= inten_c;
      thresh1_q <= THRESH_TAB[{row_i, column_i}];
      prod1_q   <= prod_c;
      inten2_q  <= inten1_q;
      thresh2_q <= thresh1_q;
      num2_q    <= num_c;
      quo2_q    <= mul_c[2*SCALED_W-1:SCALED_W];
      inten3_q  <= inten2_q;
      thresh3_q <= thresh2_q;
      scaled3_q <= quo_c;
    end
  end

  assign sc_o = '{valid: v3_q, inten: inten3_q, thresh: thresh3_q, scaled: scaled3_q};

endmodule

// ===== src/odq_dither.sv =====
module odq_dither (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  odq_pkg::scaled_t  sc_i,
  input  odq_pkg::cfg_t     cfg_i,
  output odq_pkg::step_t    st_o
);
  import odq_pkg::*;

  logic [SCALED_W+RCP255_W-1:0] mul_c;
  logic [SCALED_W-1:0]          sub_c;
  logic [SCALED_W-1:0]          frac0_c;
  logic [FRAC_W-1:0]            frac_c;
  logic [STEP_W:0]              stp_c;
  logic [DATA_W-1:0]            step_c;

  logic                v4_q, v5_q;
  logic [DATA_W-1:0]   inten4_q, thresh4_q;
  logic [SCALED_W-1:0] scaled4_q;
  logic [STEP_W-1:0]   step4_q;
  logic [DATA_W-1:0]   step5_q;

  assign mul_c   = sc_i.scaled * RCP_255;
  assign sub_c   = {step4_q, 8'h00} - {8'h00, step4_q};
  assign frac0_c = scaled4_q - sub_c;

  // estimate may be one low: fold the fraction back, dither, cap; full mode passes intensity
  always_comb begin
    frac_c = frac0_c[FRAC_W-1:0];
    stp_c  = {1'b0, step4_q};
    if (frac_c >= FRAC_W'(MAX_CODE)) begin
      frac_c = frac_c - FRAC_W'(MAX_CODE);
      stp_c  = stp_c + (STEP_W + 1)'(1);
    end
    if (frac_c > {1'b0, thresh4_q}) begin
      stp_c = stp_c + (STEP_W + 1)'(1);
    end
    if (stp_c > (STEP_W + 1)'(cfg_i.top)) begin
      stp_c = (STEP_W + 1)'(cfg_i.top);
    end
    step_c = cfg_i.full ? inten4_q : stp_c[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= sc_i.valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten4_q  <= sc_i.inten;
      thresh4_q <= sc_i.thresh;
      scaled4_q <= sc_i.scaled;
      step4_q   <= mul_c[SCALED_W+STEP_W-1:SCALED_W];
      step5_q   <= step_c;
    end
  end

  assign st_o = '{valid: v5_q, step: step5_q};

endmodule

// ===== src/odq_rescale.sv =====
module odq_rescale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  odq_pkg::step_t              st_i,
  input  odq_pkg::cfg_t               cfg_i,
  output logic                        valid_o,
  output logic [odq_pkg::DATA_W-1:0]  drive_value_o
);
  import odq_pkg::*;

  logic [X_W-1:0]         x_c;
  logic [X_W+RCP_W-1:0]   mul_c;
  logic [X_W+DATA_W-1:0]  back_c;
  logic [X_W-1:0]         rem_c;
  logic [X_W-1:0]         quo_c;

  logic              v6_q, out_valid_q;
  logic [X_W-1:0]    x6_q, quo6_q;
  logic [DATA_W-1:0] drive_q;

  assign x_c    = {st_i.step, 8'h00} - {8'h00, st_i.step};
  assign mul_c  = x_c * cfg_i.rcp;
  assign back_c = quo6_q * cfg_i.div;
  assign rem_c  = x6_q - back_c[X_W-1:0];
  assign quo_c  = quo6_q + X_W'(rem_c >= X_W'(cfg_i.div));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v6_q        <= st_i.valid;
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x6_q    <= x_c;
      quo6_q  <= mul_c[2*X_W-1:X_W];
      drive_q <= (quo_c > X_W'(MAX_CODE)) ? DATA_W'(MAX_CODE) : quo_c[DATA_W-1:0];
    end
  end

  assign valid_o       = out_valid_q;
  assign drive_value_o = drive_q;

endmodule

// ===== src/ordered_dither_quantizer_core.sv =====
// Ordered-dither quantizer: 4x4 Bayer dither of a pixel intensity into an
// 8-bit panel drive value.
//
// Input channel: in_valid_i/in_ready_o carry one request of intensity_i,
// column_i and row_i (only the low two coordinate bits are used).
// Output channel: out_valid_o/out_ready_i carry drive_value_o, one result
// per request, in request order.
// Config: cfg_we_i writes cfg_wdata_i as the panel level count; write it
// only while the pipeline is empty.
// Throughput: one request per clock while the receiver does not stall.
// Depth: seven register stages between the request and the outputs. The
// quotient steps use reciprocal multiplies with one correction stage
// each, which sets the depth.
// Stall: the whole pipeline freezes while a result waits; in_ready_o drops
// only when out_valid_o is high and out_ready_i is low.
// Reset: pipeline empties, panel level count returns to 2.
module ordered_dither_quantizer_core #(
  parameter int unsigned INTERNAL_LEVELS = 16,
  parameter int unsigned MAX_INTENSITY   = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [odq_pkg::DATA_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [odq_pkg::DATA_W-1:0]   intensity_i,
  input  logic [odq_pkg::COORD_W-1:0]  column_i,
  input  logic [odq_pkg::COORD_W-1:0]  row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [odq_pkg::DATA_W-1:0]   drive_value_o
);
  import odq_pkg::*;

  cfg_t    cfg;
  scaled_t sc;
  step_t   st;
  logic    en;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  odq_cfg #(
    .INTERNAL_LEVELS(INTERNAL_LEVELS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  odq_scale #(
    .INTERNAL_LEVELS(INTERNAL_LEVELS),
    .MAX_INTENSITY  (MAX_INTENSITY)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .intensity_i(intensity_i),
    .column_i   (column_i[1:0]),
    .row_i      (row_i[1:0]),
    .cfg_i      (cfg),
    .sc_o       (sc)
  );

  odq_dither u_dither (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .sc_i  (sc),
    .cfg_i (cfg),
    .st_o  (st)
  );

  odq_rescale u_rescale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .st_i         (st),
    .cfg_i        (cfg),
    .valid_o      (out_valid_o),
    .drive_value_o(drive_value_o)
  );

endmodule

// ===== src/odq_checker.sv =====
module odq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] intensity_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] drive_value_o
);

  logic acc;
  logic run;

  assign acc = rst_ni && in_valid_i && in_ready_o;
  assign run = rst_ni && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow output stall");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc, 6) && $past(run, 5) && $past(run, 4) && $past(run, 3) &&
    $past(run, 2) && $past(run, 1) && run |=> out_valid_o)
    else $error("request lost in pipeline");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc, 6) && ($past(intensity_i, 6) == 8'd0) && $past(run, 5) &&
    $past(run, 4) && $past(run, 3) && $past(run, 2) && $past(run, 1) && run
    |=> drive_value_o == 8'd0)
    else $error("zero intensity gave nonzero drive");

endmodule

bind ordered_dither_quantizer_core odq_checker u_odq_checker (.*);

// ===== tb/drive_value_checker.sv =====
module drive_value_checker #(
  parameter int unsigned INTERNAL_LEVELS = 16,
  parameter int unsigned MAX_INTENSITY   = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [odq_pkg::DATA_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [odq_pkg::DATA_W-1:0]   intensity_i,
  input  logic [odq_pkg::COORD_W-1:0]  column_i,
  input  logic [odq_pkg::COORD_W-1:0]  row_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [odq_pkg::DATA_W-1:0]   drive_value_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_count_o
);

  import odq_pkg::*;

  // Bayer rank per [row][column]
  localparam int unsigned BAYER_RANK [4][4] = '{
    '{ 0,  8,  2, 10},
    '{12,  4, 14,  6},
    '{ 3, 11,  1,  9},
    '{15,  7, 13,  5}
  };

  logic [DATA_W-1:0] panel_levels_q;
  logic [DATA_W-1:0] expected_drive_q [$];
  logic [DATA_W-1:0] oldest_drive;
  int unsigned       mismatches;

  function automatic logic [DATA_W-1:0] predict_drive(
    logic [DATA_W-1:0] inten,
    logic [1:0]        col,
    logic [1:0]        row,
    logic [DATA_W-1:0] levels
  );
    int unsigned level, lv, top, scaled, step, frac, thresh, res;
    if (inten == 0) return '0;
    level = (inten > MAX_INTENSITY) ? MAX_INTENSITY : inten;
    lv    = (levels < 2) ? 2 : levels;
    if (lv >= INTERNAL_LEVELS) begin
      res = (level * 255) / (INTERNAL_LEVELS - 1);
      if (res > 255) res = 255;
    end else begin
      top    = lv - 1;
      scaled = (level * top * 255) / (INTERNAL_LEVELS - 1);
      step   = scaled / 255;
      frac   = scaled - step * 255;
      thresh = (BAYER_RANK[row][col] * 255) / 16;
      if (frac > thresh) step++;
      if (step > top) step = top;
      res = (step * 255) / top;
    end
    return res[DATA_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_levels_q = 8'd2;
      expected_drive_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (cfg_we_i) panel_levels_q = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: unexpected drive_value, expected none, actual %0d",
                   $time, drive_value_i);
          mismatches++;
        end else begin
          oldest_drive = expected_drive_q.pop_front();
          if (drive_value_i !== oldest_drive) begin
            $display("%0t: drive_value mismatch, expected %0d, actual %0d",
                     $time, oldest_drive, drive_value_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_drive_q.push_back(predict_drive(intensity_i, column_i[1:0], row_i[1:0],
                                                 panel_levels_q));
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_drive_q.size();
    end
  end

endmodule

// ===== tb/ordered_dither_quantizer_core_tb.sv =====
module ordered_dither_quantizer_core_tb;

  import odq_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned PIPE_SETTLE    = 12;
  localparam int unsigned LEVEL_PLAN [14] = '{0, 1, 2, 3, 4, 5, 7, 8, 15, 16, 17, 128, 255, 0};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [DATA_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [DATA_W-1:0]   intensity;
  logic [COORD_W-1:0]  column;
  logic [COORD_W-1:0]  row;
  logic                out_valid;
  logic                out_ready;
  logic [DATA_W-1:0]   drive_value;
  int unsigned         mismatch_count;
  int unsigned         pending_count;
  int unsigned         cycle_count;
  bit                  steady;

  ordered_dither_quantizer_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .intensity_i  (intensity),
    .column_i     (column),
    .row_i        (row),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .drive_value_o(drive_value)
  );

  drive_value_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .intensity_i     (intensity),
    .column_i        (column),
    .row_i           (row),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .drive_value_i   (drive_value),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 2-state counter starts at zero
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request; returns right after the accepting edge with valid still high
  task automatic push_pixel(logic [DATA_W-1:0] inten, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] rw);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    intensity <= inten;
    column    <= col;
    row       <= rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic push_random_pixel();
    logic [DATA_W-1:0] inten;
    inten = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 255))
                                        : DATA_W'($urandom_range(0, 16));
    push_pixel(inten, COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
  endtask

  initial begin
    int unsigned levels;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    intensity = '0;
    column    = '0;
    row       = '0;
    steady    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset level count: ramp of intensities across every dither cell
    for (int k = 0; k < 16; k++)
      push_pixel(DATA_W'(k), {10'($urandom), 2'(k)}, {10'($urandom), 2'(k >> 2)});
    push_pixel(8'd16, 12'h000, 12'hFFF);
    push_pixel(8'd255, 12'hFFF, 12'hFFF);
    push_pixel(8'd128, 12'h000, 12'h000);
    push_pixel(8'd127, 12'hFFC, 12'h003);
    push_pixel(8'd1, 12'hAAA, 12'h555);

    for (int p = 0; p < 14; p++) begin
      drain_pipeline();
      levels = (p == 13) ? $urandom_range(0, 255) : LEVEL_PLAN[p];
      cfg_we    <= 1'b1;
      cfg_wdata <= DATA_W'(levels);
      @(posedge clk);
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
        push_random_pixel();
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule
